// ----- sv/sffd_pkg.sv -----
// Shared types, constants and length decoding for the serial frame field decoder.
`timescale 1ns / 1ps
package sffd_pkg;

	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	localparam logic [1:0] REG_VERSION  = 2'd0;
	localparam logic [1:0] REG_ACK_EN   = 2'd1;
	localparam logic [1:0] REG_ACK_BYTE = 2'd2;

	localparam logic [1:0] VERSION_RESET   = 2'd2;
	localparam logic       ACK_EN_RESET    = 1'b0;
	localparam logic [7:0] ACK_BYTE_RESET  = 8'd126;
	localparam logic [7:0] ACK_V1_VALUE    = 8'h7E;
	localparam logic [1:0] VERSION_V10     = 2'd0;

	localparam logic [3:0] KIND_UNEXPECTED = 4'd0;
	localparam logic [3:0] KIND_BREAK      = 4'd1;
	localparam logic [3:0] KIND_ID1        = 4'd2;
	localparam logic [3:0] KIND_ID2        = 4'd3;
	localparam logic [3:0] KIND_INSTR1     = 4'd4;
	localparam logic [3:0] KIND_INSTR2     = 4'd5;
	localparam logic [3:0] KIND_DATA0      = 4'd6;
	localparam logic [3:0] KIND_DATA       = 4'd7;
	localparam logic [3:0] KIND_CRC1       = 4'd8;
	localparam logic [3:0] KIND_CRC2       = 4'd9;
	localparam logic [3:0] KIND_ACK        = 4'd10;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_ID1   = 4'd1,
		ST_ID2   = 4'd2,
		ST_INS1  = 4'd3,
		ST_INS2  = 4'd4,
		ST_DATA0 = 4'd5,
		ST_DATA  = 4'd6,
		ST_CRC1  = 4'd7,
		ST_CRC2  = 4'd8,
		ST_ACK   = 4'd9
	} frame_state_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_break;
		logic       framing_error;
		logic       line_toggling;
	} ev_item_t;

	typedef struct packed {
		logic [3:0]  field_kind;
		logic [7:0]  field_byte;
		logic [6:0]  data_index;
		logic [7:0]  frame_length;
		logic [15:0] received_crc;
		logic        break_expected;
		logic        byte_error;
		logic        header_toggling;
		logic        reception_failed;
		logic        byte_missed;
		logic        packet_start;
		logic        packet_end;
	} field_item_t;

	typedef struct packed {
		logic [1:0] protocol_version;
		logic       ack_enable;
		logic [7:0] expected_ack;
	} cfg_t;

	typedef struct packed {
		frame_state_t frame_state;
		logic [7:0]   id_first;
		logic [7:0]   id_second;
		logic [7:0]   bytes_left;
		logic [15:0]  crc_word;
	} dec_state_t;

	function automatic logic [2:0] ones6(input logic [5:0] v);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 0; i < 6; i++) begin
			n = n + {2'b00, v[i]};
		end
		return n;
	endfunction

	function automatic logic [7:0] payload_length(input logic [1:0] ver,
			input logic [7:0] id1, input logic [7:0] id2);
		logic [2:0] len3;
		logic [7:0] len8;
		logic [7:0] res;
		len3 = id2[5:3];
		len8 = {5'd0, len3};
		if (ver[1]) begin
			if (!id2[1]) begin
				if (len3 == 3'd6) res = 8'd18;
				else if (len3 == 3'd7) res = 8'd24;
				else res = {len8[6:0], 1'b0};
			end else begin
				if (len3 == 3'd0) res = 8'd6;
				else if (len3 == 3'd6) res = 8'd84;
				else if (len3 == 3'd7) res = 8'd128;
				else res = (len8 << 3) + (len8 << 2);
			end
		end else if (!id1[0]) begin
			res = 8'(ones6({3'b000, id2[4:2]})) * 8'd6;
		end else if (ver == VERSION_V10) begin
			res = 8'(ones6(id2[7:2])) * 8'd6;
		end else begin
			res = ({2'b00, id2[7:2]} + 8'd1) << 1;
		end
		return res;
	endfunction

endpackage

// ----- sv/sffd_cfg.sv -----
// Register file for the decoder settings behind an APB-style port.
`timescale 1ns / 1ps
module sffd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sffd_pkg::AddrWidth-1:0]  paddr,
	input  logic [sffd_pkg::DataWidth-1:0]  pwdata,
	output logic [sffd_pkg::DataWidth-1:0]  prdata,
	output logic                            pready,
	output sffd_pkg::cfg_t                  cfg
);

	sffd_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol_version <= sffd_pkg::VERSION_RESET;
			cfg_q.ack_enable       <= sffd_pkg::ACK_EN_RESET;
			cfg_q.expected_ack     <= sffd_pkg::ACK_BYTE_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				sffd_pkg::REG_VERSION:  cfg_q.protocol_version <= pwdata[1:0];
				sffd_pkg::REG_ACK_EN:   cfg_q.ack_enable <= pwdata[0];
				sffd_pkg::REG_ACK_BYTE: cfg_q.expected_ack <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sffd_pkg::REG_VERSION:  prdata = {30'd0, cfg_q.protocol_version};
			sffd_pkg::REG_ACK_EN:   prdata = {31'd0, cfg_q.ack_enable};
			sffd_pkg::REG_ACK_BYTE: prdata = {24'd0, cfg_q.expected_ack};
			default:                prdata = '0;
		endcase
	end

endmodule

// ----- sv/sffd_decode.sv -----
// Field labeling and next frame state for one receiver event.
`timescale 1ns / 1ps
module sffd_decode (
	input  sffd_pkg::cfg_t       cfg,
	input  sffd_pkg::dec_state_t cur,
	input  sffd_pkg::ev_item_t   ev,
	output sffd_pkg::dec_state_t nxt,
	output sffd_pkg::field_item_t res
);

	logic       v2;
	logic       in_frame;
	logic       byte_path;
	logic [7:0] b;
	logic [7:0] id2_eff;
	logic [7:0] len;
	logic [7:0] diff;
	logic [7:0] ack_exp;
	logic       ack_follows;

	assign v2        = cfg.protocol_version[1];
	assign b         = ev.rx_byte;
	assign in_frame  = (cur.frame_state != sffd_pkg::ST_IDLE) &
		(cur.frame_state <= sffd_pkg::ST_ACK);
	assign byte_path = in_frame & ~ev.is_break;
	assign id2_eff   = (cur.frame_state == sffd_pkg::ST_ID2) ? b : cur.id_second;
	assign len       = sffd_pkg::payload_length(cfg.protocol_version, cur.id_first, id2_eff);
	assign diff      = len - cur.bytes_left;
	assign ack_exp   = v2 ? cfg.expected_ack : sffd_pkg::ACK_V1_VALUE;
	assign ack_follows = cfg.ack_enable & (v2 ? ~cur.id_second[0] : ~cur.id_first[1]);

	always_comb begin
		nxt = cur;
		res = '0;
		res.byte_error   = ev.framing_error;
		res.field_byte   = ev.is_break ? 8'd0 : b;
		res.byte_missed  = ev.is_break & in_frame;
		if (!in_frame) begin
			res.header_toggling = ev.line_toggling;
		end
		if (ev.is_break) begin
			res.field_kind   = sffd_pkg::KIND_BREAK;
			res.packet_start = 1'b1;
			nxt.frame_state  = sffd_pkg::ST_ID1;
		end else if (!in_frame) begin
			res.field_kind     = sffd_pkg::KIND_UNEXPECTED;
			res.break_expected = 1'b1;
			nxt.frame_state    = sffd_pkg::ST_IDLE;
		end else begin
			unique case (cur.frame_state)
				sffd_pkg::ST_ID1: begin
					res.field_kind  = sffd_pkg::KIND_ID1;
					nxt.id_first    = b;
					nxt.frame_state = sffd_pkg::ST_ID2;
				end
				sffd_pkg::ST_ID2: begin
					res.field_kind = sffd_pkg::KIND_ID2;
					nxt.id_second  = b;
					nxt.bytes_left = len;
					if (v2 && b[2]) nxt.frame_state = sffd_pkg::ST_INS1;
					else if (len == 8'd0) nxt.frame_state = sffd_pkg::ST_CRC1;
					else nxt.frame_state = sffd_pkg::ST_DATA0;
				end
				sffd_pkg::ST_INS1: begin
					res.field_kind  = sffd_pkg::KIND_INSTR1;
					nxt.frame_state = sffd_pkg::ST_INS2;
				end
				sffd_pkg::ST_INS2: begin
					res.field_kind  = sffd_pkg::KIND_INSTR2;
					nxt.frame_state = (cur.bytes_left == 8'd0) ?
						sffd_pkg::ST_CRC1 : sffd_pkg::ST_DATA0;
				end
				sffd_pkg::ST_DATA0, sffd_pkg::ST_DATA: begin
					res.field_kind = (cur.frame_state == sffd_pkg::ST_DATA0) ?
						sffd_pkg::KIND_DATA0 : sffd_pkg::KIND_DATA;
					res.data_index  = diff[6:0];
					nxt.frame_state = (cur.bytes_left <= 8'd1) ?
						sffd_pkg::ST_CRC1 : sffd_pkg::ST_DATA;
					if (cur.bytes_left != 8'd0) nxt.bytes_left = cur.bytes_left - 8'd1;
				end
				sffd_pkg::ST_CRC1: begin
					res.field_kind  = sffd_pkg::KIND_CRC1;
					nxt.crc_word    = {8'd0, b};
					nxt.frame_state = sffd_pkg::ST_CRC2;
				end
				sffd_pkg::ST_CRC2: begin
					res.field_kind = sffd_pkg::KIND_CRC2;
					nxt.crc_word = v2 ? (cur.crc_word | {b, 8'd0}) : {cur.crc_word[7:0], b};
					res.received_crc = nxt.crc_word;
					if (ack_follows) begin
						nxt.frame_state = sffd_pkg::ST_ACK;
					end else begin
						nxt.frame_state = sffd_pkg::ST_IDLE;
						res.packet_end  = 1'b1;
					end
				end
				sffd_pkg::ST_ACK: begin
					res.field_kind       = sffd_pkg::KIND_ACK;
					res.reception_failed = (b != ack_exp);
					nxt.bytes_left       = 8'd0;
					nxt.frame_state      = sffd_pkg::ST_IDLE;
					res.packet_end       = 1'b1;
				end
				default: begin
					res.field_kind  = sffd_pkg::KIND_UNEXPECTED;
					nxt.frame_state = sffd_pkg::ST_IDLE;
				end
			endcase
			if (byte_path && cur.frame_state != sffd_pkg::ST_ID1) begin
				res.frame_length = len;
			end
		end
	end

endmodule

// ----- sv/serial_frame_field_decoder_unit.sv -----
// Top level of the serial frame field decoder: input stage, decode and result register.
`timescale 1ns / 1ps
// An accepted event is held in the input stage, then decoded into the result register.
// One event per cycle; field_stall on a full result register stalls a full input stage.
// The frame state is updated as an event moves from the input stage into the result register.
// Reset clears the frame state to idle, empties both stages and loads the register defaults.
module serial_frame_field_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ev_valid,
	output logic                            ev_stall,
	input  sffd_pkg::ev_item_t              ev_item,
	output logic                            field_valid,
	input  logic                            field_stall,
	output sffd_pkg::field_item_t           field_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sffd_pkg::AddrWidth-1:0]  paddr,
	input  logic [sffd_pkg::DataWidth-1:0]  pwdata,
	output logic [sffd_pkg::DataWidth-1:0]  prdata,
	output logic                            pready
);

	sffd_pkg::cfg_t        cfg;
	sffd_pkg::ev_item_t    item_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	sffd_pkg::field_item_t res_s2;
	sffd_pkg::field_item_t res_d;
	sffd_pkg::dec_state_t  state_q;
	sffd_pkg::dec_state_t  state_d;
	logic                  adv_s2;
	logic                  adv_s1;
	logic                  ev_xfer;

	sffd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sffd_decode u_decode (
		.cfg (cfg),
		.cur (state_q),
		.ev  (item_s1),
		.nxt (state_d),
		.res (res_d)
	);

	assign adv_s2      = ~valid_s2 | ~field_stall;
	assign adv_s1      = valid_s1 & adv_s2;
	assign ev_stall    = valid_s1 & ~adv_s2;
	assign ev_xfer     = ev_valid & ~ev_stall;
	assign field_valid = valid_s2;
	assign field_item  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.frame_state <= sffd_pkg::ST_IDLE;
			state_q.id_first    <= 8'd0;
			state_q.id_second   <= 8'd0;
			state_q.bytes_left  <= 8'd0;
			state_q.crc_word    <= 16'd0;
		end else begin
			if (ev_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_xfer) begin
			item_s1 <= ev_item;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	a_break_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.is_break |=> state_q.frame_state == sffd_pkg::ST_ID1)
		else $error("break transfer did not move the frame state to ID1");

	a_start_is_break: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.packet_start == (res_s2.field_kind == sffd_pkg::KIND_BREAK)))
		else $error("packet start flag disagrees with field kind");

	a_missing_on_break: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.byte_missed |-> res_s2.packet_start)
		else $error("missing byte reported on a field that is not a break");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stall |-> valid_s1 && valid_s2)
		else $error("input stalled while the pipeline has room");

	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_d.packet_end |=> state_q.frame_state == sffd_pkg::ST_IDLE)
		else $error("frame state not idle after the end of a packet");

endmodule
